// ----- hw/rtl/bps_pkg.sv -----
package bps_pkg;

  localparam int unsigned MaxNumbersDef = 65536;
  localparam int unsigned LimitW        = 17;
  localparam int unsigned IdxW          = 11;
  localparam int unsigned WordW         = 32;
  localparam int unsigned RootW         = 9;
  localparam int unsigned SqW           = LimitW + 1;
  localparam int unsigned WcntW         = LimitW - 4;
  localparam logic [LimitW-1:0] LimitRst = LimitW'(65536);

  typedef enum logic {
    MODE_BUILD = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  typedef struct packed {
    logic            mode;
    logic [IdxW-1:0] word_index;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             out_of_range;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_TEST,
    S_RDI,
    S_CHKI,
    S_RDJ,
    S_WRJ,
    S_NEXTI,
    S_DONE
  } step_e;

  typedef enum logic [3:0] {
    OP_INIT,
    OP_NONE,
    OP_FILL,
    OP_RDI,
    OP_LDJ,
    OP_RDJ,
    OP_WRJ,
    OP_NEXTI,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_BUILD,
    C_FILL_DONE,
    C_OUTER_DONE,
    C_BIT_CLR,
    C_INNER_DONE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e tgt;
    step_e nxt;
  } uword_t;

  typedef struct packed {
    logic build_go;
    logic fill_done;
    logic outer_done;
    logic bit_clr;
    logic inner_done;
  } flags_t;

  typedef struct packed {
    op_e  op;
    logic busy;
  } ctrl_t;

  // microcode rom: op, jump condition, jump target, fall-through step
  function automatic uword_t ucode(step_e s);
    uword_t w;
    case (s)
      S_IDLE:  w = '{op: OP_INIT,   cond: C_BUILD,      tgt: S_FILL,  nxt: S_IDLE};
      S_FILL:  w = '{op: OP_FILL,   cond: C_FILL_DONE,  tgt: S_TEST,  nxt: S_FILL};
      S_TEST:  w = '{op: OP_NONE,   cond: C_OUTER_DONE, tgt: S_DONE,  nxt: S_RDI};
      S_RDI:   w = '{op: OP_RDI,    cond: C_NEVER,      tgt: S_IDLE,  nxt: S_CHKI};
      S_CHKI:  w = '{op: OP_LDJ,    cond: C_BIT_CLR,    tgt: S_NEXTI, nxt: S_RDJ};
      S_RDJ:   w = '{op: OP_RDJ,    cond: C_INNER_DONE, tgt: S_NEXTI, nxt: S_WRJ};
      S_WRJ:   w = '{op: OP_WRJ,    cond: C_NEVER,      tgt: S_IDLE,  nxt: S_RDJ};
      S_NEXTI: w = '{op: OP_NEXTI,  cond: C_NEVER,      tgt: S_IDLE,  nxt: S_TEST};
      S_DONE:  w = '{op: OP_FINISH, cond: C_NEVER,      tgt: S_IDLE,  nxt: S_IDLE};
      default: w = '{op: OP_NONE,   cond: C_NEVER,      tgt: S_IDLE,  nxt: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/bitmap_prime_sieve.sv -----
// Sieve of Eratosthenes bitmap. A request with mode build fills the words in use with ones
// and then strikes out multiples, from i*i up, of every i still unstruck with i*i below
// the limit. busy_o stays high while it fills the words, tests each i from 2 up, reads the
// word of each i and, for each unstruck i, reads and writes the word of each multiple.
// The bitmap memory is single-port, so each strike is a read and then a write.
// A read request is taken in any cycle busy_o is low, back to back; its word appears in
// the next cycle. Every request taken gives exactly one result, shown for one cycle under
// rsp_valid_o; the receiver cannot stall it, so it must take each result when it appears.
// The bitmap is not cleared at reset; reads before the first build or past the built
// words are flagged.
module bitmap_prime_sieve
  import bps_pkg::*;
#(
  parameter int unsigned MaxNumbers = MaxNumbersDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  req_t              req_i,
  output logic              rsp_valid_o,
  output rsp_t              rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_limit_i
);

  localparam int unsigned Depth = (MaxNumbers + 31) / 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ExtW  = (AddrW > WcntW) ? AddrW : WcntW;

  logic [WordW-1:0]  mem [Depth];
  logic [WordW-1:0]  rdata_q;
  logic [LimitW-1:0] limit_q;
  logic [WcntW-1:0]  used_words_q;
  logic              built_q;
  logic              rsp_valid_q, rsp_oor_q, rsp_zero_q;
  logic [WcntW-1:0]  w_q;
  logic [RootW-1:0]  i_q;
  logic [SqW-1:0]    sq_q, j_q;

  ctrl_t             ctrl;
  flags_t            flags;
  logic [LimitW-1:0] lim;
  logic [WcntW-1:0]  words;
  logic              rd_accept, rd_oor;
  logic [WcntW-1:0]  word_num;
  logic [ExtW-1:0]   addr_ext;
  logic [AddrW-1:0]  mem_addr;
  logic              mem_we, mem_re;
  logic [WordW-1:0]  mem_wdata;

  bps_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign busy_o      = ctrl.busy;
  assign cfg_ready_o = ~ctrl.busy & ~start_i;

  always_comb begin
    lim   = (32'(limit_q) > MaxNumbers) ? LimitW'(MaxNumbers) : limit_q;
    words = WcntW'((SqW'(lim) + SqW'(31)) >> 5);

    flags.build_go   = start_i & (req_i.mode == MODE_BUILD);
    flags.fill_done  = (w_q >= words);
    flags.outer_done = (sq_q >= SqW'(lim));
    flags.bit_clr    = ~rdata_q[i_q[4:0]];
    flags.inner_done = (j_q >= SqW'(lim));

    rd_accept = start_i & ~ctrl.busy & (req_i.mode == MODE_READ);
    rd_oor    = ~built_q | (WcntW'(req_i.word_index) >= used_words_q)
                | (32'(req_i.word_index) >= Depth);
  end

  // one address per cycle for the single-port bitmap
  always_comb begin
    case (ctrl.op)
      OP_FILL:        word_num = w_q;
      OP_RDI:         word_num = WcntW'(i_q[RootW-1:5]);
      OP_RDJ, OP_WRJ: word_num = j_q[SqW-1:5];
      default:        word_num = WcntW'(req_i.word_index);
    endcase
    addr_ext  = ExtW'(word_num);
    mem_addr  = addr_ext[AddrW-1:0];
    mem_we    = ((ctrl.op == OP_FILL) & ~flags.fill_done) | (ctrl.op == OP_WRJ);
    mem_re    = rd_accept | (ctrl.op == OP_RDI) | (ctrl.op == OP_RDJ);
    mem_wdata = (ctrl.op == OP_FILL) ? '1 : (rdata_q & ~(WordW'(1) << j_q[4:0]));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // sieve counters
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      OP_INIT: begin
        w_q  <= '0;
        i_q  <= RootW'(2);
        sq_q <= SqW'(4);
      end
      OP_FILL: begin
        if (!flags.fill_done) begin
          w_q <= w_q + WcntW'(1);
        end
      end
      OP_LDJ: begin
        j_q <= sq_q;
      end
      OP_WRJ: begin
        j_q <= j_q + SqW'(i_q);
      end
      OP_NEXTI: begin
        sq_q <= sq_q + SqW'({i_q, 1'b1});
        i_q  <= i_q + RootW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LimitRst;
      used_words_q <= '0;
      built_q      <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_limit_i;
      end
      if (ctrl.op == OP_FINISH) begin
        used_words_q <= words;
        built_q      <= 1'b1;
      end
      rsp_valid_q <= rd_accept | (ctrl.op == OP_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_accept) begin
      rsp_oor_q  <= rd_oor;
      rsp_zero_q <= rd_oor;
    end else if (ctrl.op == OP_FINISH) begin
      rsp_oor_q  <= 1'b0;
      rsp_zero_q <= 1'b1;
    end
  end

  assign rsp_valid_o        = rsp_valid_q;
  assign rsp_o.word         = rsp_zero_q ? '0 : rdata_q;
  assign rsp_o.out_of_range = rsp_oor_q;

endmodule

// ----- hw/rtl/bps_seq.sv -----
module bps_seq
  import bps_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  step_e  pc_q, pc_d;
  uword_t uw;
  logic   taken;

  always_comb begin
    uw = ucode(pc_q);
    case (uw.cond)
      C_NEVER:      taken = 1'b0;
      C_BUILD:      taken = flags_i.build_go;
      C_FILL_DONE:  taken = flags_i.fill_done;
      C_OUTER_DONE: taken = flags_i.outer_done;
      C_BIT_CLR:    taken = flags_i.bit_clr;
      C_INNER_DONE: taken = flags_i.inner_done;
      default:      taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_d = taken ? uw.tgt : uw.nxt;
  end

  // control word out
  always_comb begin
    ctrl_o.op   = uw.op;
    ctrl_o.busy = (pc_q != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hw/rtl/bps_checker.sv -----
module bps_checker
  import bps_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic rsp_valid_o,
  input rsp_t rsp_o,
  input logic cfg_ready_o
);

  // build request starts a busy phase
  a_build_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.mode == MODE_BUILD) |=> busy_o)
    else $error("build request did not raise busy");

  // read request answered next cycle
  a_read_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.mode == MODE_READ) |=> rsp_valid_o)
    else $error("read request got no result");

  // end of build gives its result
  a_build_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> rsp_valid_o)
    else $error("build ended without result");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.out_of_range |-> (rsp_o.word == '0))
    else $error("flagged read returned data");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy_o)
    else $error("config taken while busy");

endmodule

bind bitmap_prime_sieve bps_checker u_bps_checker (.*);
